>>> rtl/core/sccp_pkg.sv
package sccp_pkg;

    // Horner accumulator: holds every coefficient and every partial sum
    localparam int ACC_W   = 35;
    localparam int Y30_W   = 32;
    localparam int Y2_W    = 30;
    localparam int NUM_STEPS = 5;

    typedef logic signed [ACC_W-1:0] acc_t;

    // Coefficients in Q.32, top term first
    localparam acc_t SIN_COEF [0:NUM_STEPS] = '{
        -35'sd103, 35'sd11822, -35'sd852159, 35'sd35791384,
        -35'sd715827897, 35'sd4294967296
    };
    localparam acc_t COS_COEF [0:NUM_STEPS] = '{
        -35'sd1119, 35'sd106346, -35'sd5965013, 35'sd178956848,
        -35'sd2147483648, 35'sd4294967296
    };

    // Payload carried down the polynomial stages
    typedef struct packed {
        logic signed [Y30_W-1:0] y30;   // reduced angle, Q.30
        logic [Y2_W-1:0]         y2;    // square of reduced angle, Q.28
        logic                    flip;  // negate cosine
        acc_t                    sacc;  // sine accumulator
        acc_t                    cacc;  // cosine accumulator
    } sccp_beat_t;

endpackage

>>> rtl/core/sccp_reduce.sv
module sccp_reduce
    import sccp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] in_angle,
    output logic               out_valid,
    output sccp_beat_t         out_beat
);

    localparam int DEPTH = 9;
    localparam logic [29:0]        INV2PI_Q32 = 30'h28BE60DC;
    localparam logic signed [57:0] TWOPI_Q48  = 58'sh6487ED5110B46;
    localparam logic signed [57:0] PI_Q48     = 58'sh3243F6A8885A3;
    localparam logic signed [57:0] HALFPI_Q48 = 58'sh1921FB54442D2;

    logic [DEPTH-1:0] v_reg, v_next;

    logic signed [31:0] a1_reg, a2_reg, a3_reg, a4_reg;
    logic [31:0]        mag1_reg, mag_next;
    logic [61:0]        prod2_reg, prod_next;
    logic               neg2_reg;
    logic [61:0]        ksum;
    logic [5:0]         kmag;
    logic signed [5:0]  k3_reg, k_next;
    logic signed [57:0] kt4_reg, kt_next;
    logic signed [57:0] y5_reg, y48_next;
    logic signed [57:0] y6_reg, fold_next;
    logic               flip6_reg, flip_next;
    logic [57:0]        rnd30;
    logic signed [31:0] y30_7_reg, y30_8_reg, y30_9_reg, y30_next;
    logic               flip7_reg, flip8_reg, flip9_reg;
    logic signed [63:0] sq8_reg, sq_next;
    logic [63:0]        rnd2;
    logic [29:0]        y2_9_reg, y2_next;

    // Advance valid bits with the data
    assign v_next = {v_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    // Magnitude of the angle
    assign mag_next = in_angle[31] ? 32'(-in_angle) : 32'(in_angle);

    // Quotient estimate: |angle| / 2pi, then round half away from zero
    assign prod_next = {30'd0, mag1_reg} * {32'd0, INV2PI_Q32};
    assign ksum      = prod2_reg + (62'd1 << 55);
    assign kmag      = ksum[61:56];
    assign k_next    = neg2_reg ? (6'd0 - kmag) : kmag;

    // Subtract k whole turns
    assign kt_next  = 58'(k3_reg) * TWOPI_Q48;
    assign y48_next = $signed({{2{a4_reg[31]}}, a4_reg, 24'd0}) - kt4_reg;

    // Fold into [-pi/2, pi/2]
    always_comb
    begin
        fold_next = y5_reg;
        flip_next = 1'b0;
        if (y5_reg > HALFPI_Q48)
        begin
            fold_next = PI_Q48 - y5_reg;
            flip_next = 1'b1;
        end
        else if (y5_reg < -HALFPI_Q48)
        begin
            fold_next = -PI_Q48 - y5_reg;
            flip_next = 1'b1;
        end
    end

    // Round to Q.30, then square to Q.28
    assign rnd30    = y6_reg + 58'd131072 - {57'd0, y6_reg[57]};
    assign y30_next = rnd30[49:18];
    assign sq_next  = y30_7_reg * y30_7_reg;
    assign rnd2     = sq8_reg + 64'h8000_0000;
    assign y2_next  = rnd2[61:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= in_angle;
            mag1_reg  <= mag_next;
            a2_reg    <= a1_reg;
            neg2_reg  <= a1_reg[31];
            prod2_reg <= prod_next;
            a3_reg    <= a2_reg;
            k3_reg    <= k_next;
            a4_reg    <= a3_reg;
            kt4_reg   <= kt_next;
            y5_reg    <= y48_next;
            y6_reg    <= fold_next;
            flip6_reg <= flip_next;
            y30_7_reg <= y30_next;
            flip7_reg <= flip6_reg;
            sq8_reg   <= sq_next;
            y30_8_reg <= y30_7_reg;
            flip8_reg <= flip7_reg;
            y2_9_reg  <= y2_next;
            y30_9_reg <= y30_8_reg;
            flip9_reg <= flip8_reg;
        end
    end

    assign out_valid      = v_reg[DEPTH-1];
    assign out_beat.y30   = y30_9_reg;
    assign out_beat.y2    = y2_9_reg;
    assign out_beat.flip  = flip9_reg;
    assign out_beat.sacc  = SIN_COEF[0];
    assign out_beat.cacc  = COS_COEF[0];

endmodule

>>> rtl/core/sccp_horner_step.sv
module sccp_horner_step
    import sccp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  acc_t       sin_coef,
    input  acc_t       cos_coef,
    input  logic       in_valid,
    input  sccp_beat_t in_beat,
    output logic       out_valid,
    output sccp_beat_t out_beat
);

    logic [1:0]         v_reg, v_next;
    sccp_beat_t         beat_reg, beat_next;
    logic signed [65:0] sp_reg, sp_next;
    logic signed [65:0] cp_reg, cp_next;
    logic [65:0]        srnd, crnd;

    assign v_next = {v_reg[0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    // Multiply both accumulators by the squared angle
    assign sp_next = in_beat.sacc * $signed({1'b0, in_beat.y2});
    assign cp_next = in_beat.cacc * $signed({1'b0, in_beat.y2});

    // Round back to Q.32 (half away from zero) and add the next term
    assign srnd = sp_reg + 66'd134217728 - {65'd0, sp_reg[65]};
    assign crnd = cp_reg + 66'd134217728 - {65'd0, cp_reg[65]};

    always_comb
    begin
        beat_next      = beat_reg;
        beat_next.sacc = acc_t'(srnd[62:28]) + sin_coef;
        beat_next.cacc = acc_t'(crnd[62:28]) + cos_coef;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= in_beat;
            sp_reg   <= sp_next;
            cp_reg   <= cp_next;
            out_beat <= beat_next;
        end
    end

    assign out_valid = v_reg[1];

endmodule

>>> rtl/core/sccp_output.sv
module sccp_output
    import sccp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  sccp_beat_t  in_beat,
    output logic        out_valid,
    output logic [63:0] out_data
);

    localparam logic signed [34:0] ONE_S = 35'sd1073741824;
    localparam logic signed [33:0] ONE_C = 34'sd1073741824;

    logic [1:0]         v_reg, v_next;
    logic signed [66:0] sprod_reg, sprod_next;
    logic [34:0]        crnd;
    logic signed [32:0] cval;
    logic signed [33:0] cneg_reg, cneg_next;
    logic [66:0]        srnd;
    logic signed [34:0] sval;
    logic signed [31:0] sine_next, cosine_next;
    logic [63:0]        data_reg;

    assign v_next = {v_reg[0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    // Sine: scale by the angle; cosine: drop to Q.30 and apply the fold sign
    assign sprod_next = in_beat.sacc * in_beat.y30;
    assign crnd       = in_beat.cacc + 35'd2 - {34'd0, in_beat.cacc[34]};
    assign cval       = $signed(crnd[34:2]);
    assign cneg_next  = in_beat.flip ? -34'(cval) : 34'(cval);

    // Round the sine product, then saturate both to plus or minus one
    assign srnd = sprod_reg + 67'h8000_0000 - {66'd0, sprod_reg[66]};
    assign sval = $signed(srnd[66:32]);

    always_comb
    begin
        if (sval > ONE_S)
        begin
            sine_next = 32'(ONE_S);
        end
        else if (sval < -ONE_S)
        begin
            sine_next = 32'(-ONE_S);
        end
        else
        begin
            sine_next = sval[31:0];
        end

        if (cneg_reg > ONE_C)
        begin
            cosine_next = 32'(ONE_C);
        end
        else if (cneg_reg < -ONE_C)
        begin
            cosine_next = 32'(-ONE_C);
        end
        else
        begin
            cosine_next = cneg_reg[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sprod_reg <= sprod_next;
            cneg_reg  <= cneg_next;
            data_reg  <= {cosine_next, sine_next};
        end
    end

    assign out_valid = v_reg[1];
    assign out_data  = data_reg;

endmodule

>>> rtl/core/sine_cosine_polynomial_core.sv
// Sine and cosine of a Q8.24 angle in radians, both returned as Q2.30 and
// saturated to plus or minus one. The angle is reduced by the nearest whole
// number of turns, folded into [-pi/2, pi/2] and fed to two minimax
// polynomials evaluated Horner style in the squared angle. The core takes one
// angle per clock cycle while the output is not back-pressured. The pipeline
// has nine stages of range reduction, two per Horner step for five steps,
// and two for the final scaling and saturation. A back-pressured output
// freezes the whole pipeline; a one-beat skid register keeps s_tready
// registered, so one further angle is still taken while the output waits.
module sine_cosine_polynomial_core
    import sccp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [31:0] sine, [63:32] cosine
);

    logic               en;
    logic               skid_valid_reg, skid_valid_next;
    logic [31:0]        skid_reg;
    logic               in_beat;
    logic               pipe_valid;
    logic signed [31:0] pipe_angle;

    logic       hv [0:NUM_STEPS];
    sccp_beat_t hb [0:NUM_STEPS];

    // Advance the pipeline unless a result is held at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = !skid_valid_reg;
    assign in_beat  = s_tvalid && s_tready;

    // Feed the pipeline from the skid register first
    assign pipe_valid = skid_valid_reg || in_beat;
    assign pipe_angle = skid_valid_reg ? $signed(skid_reg) : $signed(s_tdata);

    // Park a beat that arrives during a stall
    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (en)
        begin
            skid_valid_next = 1'b0;
        end
        else if (in_beat)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && in_beat)
        begin
            skid_reg <= s_tdata;
        end
    end

    sccp_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pipe_valid),
        .in_angle  (pipe_angle),
        .out_valid (hv[0]),
        .out_beat  (hb[0])
    );

    // One Horner step per coefficient below the top one
    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_step
        sccp_horner_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .sin_coef  (SIN_COEF[i+1]),
            .cos_coef  (COS_COEF[i+1]),
            .in_valid  (hv[i]),
            .in_beat   (hb[i]),
            .out_valid (hv[i+1]),
            .out_beat  (hb[i+1])
        );
    end

    sccp_output u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hv[NUM_STEPS]),
        .in_beat   (hb[NUM_STEPS]),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

>>> rtl/core/sccp_checker.sv
module sccp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Sine saturates at plus or minus one
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824) &&
                     ($signed(m_tdata[31:0]) >= -32'sd1073741824))
        else $error("sine out of range");

    // Cosine saturates at plus or minus one
    a_cosine_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[63:32]) <= 32'sd1073741824) &&
                     ($signed(m_tdata[63:32]) >= -32'sd1073741824))
        else $error("cosine out of range");

    // Input only backs off after an output stall with a beat taken
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready && s_tvalid))
        else $error("input ready dropped without an output stall");

endmodule

bind sine_cosine_polynomial_core sccp_checker u_sccp_checker (.*);
